// ===== rtl/instruction_window_rob_core_macros.svh =====
// Assertion macros used by the checker file of the instruction window.
`ifndef INSTRUCTION_WINDOW_ROB_CORE_MACROS_SVH
`define INSTRUCTION_WINDOW_ROB_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IWR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define IWR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/iwr_pkg.sv =====
// Types, constants and helpers for the instruction window.
`timescale 1ns / 1ps
package iwr_pkg;

	localparam int DEPTH      = 128;
	localparam int MAX_RETIRE = 8;
	localparam int ADDR_W     = 48;
	localparam int TIME_W     = 48;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int LIM_W      = $clog2(MAX_RETIRE + 1);
	localparam int CFG_W      = 4;
	localparam int RCNT_W     = 4;
	localparam int OCC_W      = 8;
	localparam int OP_W       = 2;

	// entry RAM layout: address, issue time, address-valid flag, ready flag
	localparam int ENT_TIME_LSB = ADDR_W;
	localparam int ENT_AV_BIT   = ENT_TIME_LSB + TIME_W;
	localparam int ENT_RDY_BIT  = ENT_AV_BIT + 1;
	localparam int ENTRY_W      = ENT_RDY_BIT + 1;

	// input word layout
	localparam int IN_RDY_BIT  = 0;
	localparam int IN_HAS_BIT  = 1;
	localparam int IN_ADDR_LSB = 2;
	localparam int IN_TIME_LSB = IN_ADDR_LSB + ADDR_W;
	localparam int IN_BITS     = IN_TIME_LSB + TIME_W;
	localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

	// output word layout
	localparam int OUT_RCNT_LSB  = 0;
	localparam int OUT_FOUND_BIT = OUT_RCNT_LSB + RCNT_W;
	localparam int OUT_TIME_LSB  = OUT_FOUND_BIT + 1;
	localparam int OUT_REJ_BIT   = OUT_TIME_LSB + TIME_W;
	localparam int OUT_FULL_BIT  = OUT_REJ_BIT + 1;
	localparam int OUT_OCC_LSB   = OUT_FULL_BIT + 1;
	localparam int OUT_BITS      = OUT_OCC_LSB + OCC_W;
	localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] RETIRE_WIDTH_RST = CFG_W'(4);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_RETIRE   = 2'd1,
		OP_COMPLETE = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_RETIRE,
		ST_RET_CHK,
		ST_SCAN,
		ST_RESP
	} state_t;

	// circular increment
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

// ===== rtl/instruction_window_rob_core.sv =====
// Top level: instruction window / reorder buffer with in-order retire.
// Each accepted word gives one result word. Insert or unused code go straight to it;
//   retire reads tail entries in turn until cap, empty window or an entry not ready.
// Complete reads every occupied entry from the tail, keeping the earliest match time.
// Throughput: one word in flight; next word taken the cycle after the result is loaded.
// Reset (arst_n low, async): pointers, count, retire_width (to 4); RAM not cleared.
`timescale 1ns / 1ps
module instruction_window_rob_core
	import iwr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [0] entry_ready, [1] has_address, [49:2] address, [97:50] issue_time, rest zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] op
	input  logic [OP_W-1:0]       s_tuser,
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [3:0] retired_count, [4] match_found, [52:5] earliest_issue_time,
	// [53] insert_rejected, [54] window_full, [62:55] occupancy, [63] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	// configuration: retire_width
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data
);

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	state_t            state_q, state_d;
	logic [PTR_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [CFG_W-1:0]  retire_width_q;

	// latched input word (payload, no reset)
	logic              rdy_q, has_q;
	logic [ADDR_W-1:0] addr_q;
	logic [TIME_W-1:0] itime_q;
	logic [LIM_W-1:0]  lim_q;

	// result accumulators
	logic [LIM_W-1:0]  n_q;
	logic              found_q;
	logic [TIME_W-1:0] best_q;
	logic              rej_q;

	// scan sequencer and read pipeline
	logic [PTR_W-1:0]  scan_idx_q;
	logic [CNT_W-1:0]  issue_left_q;
	logic              v_s1;
	logic [PTR_W-1:0]  idx_s1;
	logic              hit_s1;
	logic              v_s2, hit_s2;
	logic [TIME_W-1:0] time_s2;

	// output register
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [OUT_DATA_W-1:0] resp_word;

	// ------------------------------------------------------------------
	// Handshakes and decode
	// ------------------------------------------------------------------
	logic             in_acc;
	logic             full;
	logic [LIM_W-1:0] lim;
	op_t              op_in;

	logic do_insert, ret_issue, ret_step, scan_issue, scan_done, resp_load;

	assign in_acc    = s_tvalid & s_tready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign op_in     = op_t'(s_tuser);
	assign cfg_ready = 1'b1;   // writes must only arrive while idle; the block does not enforce it

	// saturate retire width to MAX_RETIRE; zero retires nothing
	always_comb begin
		if (int'(retire_width_q) > MAX_RETIRE) begin
			lim = LIM_W'(MAX_RETIRE);
		end else begin
			lim = LIM_W'(retire_width_q);
		end
	end

	// ------------------------------------------------------------------
	// Entry RAM: {ready, addr_valid, issue_time, address}. Only occupied
	// entries are read, and each was written by its insert first.
	// Insert, retire and scan sit in different states; during a scan the
	// write-back of a hit goes to the entry whose read data is compared,
	// never to the one being read.
	// ------------------------------------------------------------------
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [ENTRY_W-1:0] ins_word, wb_word;
	logic               ram_we, ram_re;
	logic [PTR_W-1:0]   ram_waddr, ram_raddr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [TIME_W-1:0]  rd_time;

	// new entry; an entry without address keeps zero there
	always_comb begin
		ins_word = '0;
		ins_word[ENT_RDY_BIT] = rdy_q;
		ins_word[ENT_AV_BIT]  = has_q;
		ins_word[ENT_TIME_LSB +: TIME_W] = itime_q;
		if (has_q) begin
			ins_word[0 +: ADDR_W] = addr_q;
		end
	end

	// matched entry written back as ready
	always_comb begin
		wb_word = ram_rdata;
		wb_word[ENT_RDY_BIT] = 1'b1;
	end

	assign rd_addr   = ram_rdata[0 +: ADDR_W];
	assign rd_time   = ram_rdata[ENT_TIME_LSB +: TIME_W];

	assign ram_we    = do_insert | hit_s1;
	assign ram_waddr = hit_s1 ? idx_s1 : head_q;
	assign ram_wdata = hit_s1 ? wb_word : ins_word;
	assign ram_re    = scan_issue | ret_issue;
	assign ram_raddr = scan_issue ? scan_idx_q : tail_q;

	iwr_entry_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// stage s1 compare: read data lines up with idx_s1
	assign hit_s1 = v_s1 & ram_rdata[ENT_AV_BIT] & (rd_addr == addr_q);

	// ------------------------------------------------------------------
	// FSM: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (op_in)
						OP_INSERT:   state_d = ST_INSERT;
						OP_RETIRE:   state_d = ST_RETIRE;
						OP_COMPLETE: state_d = ST_SCAN;
						default:     state_d = ST_RESP;
					endcase
				end
			end
			ST_INSERT: state_d = ST_RESP;
			// read the tail entry, or finish on empty window / cap reached
			ST_RETIRE: begin
				if (ret_issue) begin
					state_d = ST_RET_CHK;
				end else begin
					state_d = ST_RESP;
				end
			end
			// tail entry read back: retire it if ready, else stop
			ST_RET_CHK: begin
				if (ret_step) begin
					state_d = ST_RETIRE;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (resp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// FSM: outputs
	// ------------------------------------------------------------------
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		do_insert  = (state_q == ST_INSERT) && !full;
		ret_issue  = (state_q == ST_RETIRE) && (count_q != '0) && (n_q < lim_q);
		ret_step   = (state_q == ST_RET_CHK) && ram_rdata[ENT_RDY_BIT];
		scan_issue = (state_q == ST_SCAN) && (issue_left_q != '0);
		scan_done  = (state_q == ST_SCAN) && (issue_left_q == '0) && !v_s1 && !v_s2;
		resp_load  = (state_q == ST_RESP) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retire_width_q <= RETIRE_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			retire_width_q <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// Latched word
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rdy_q   <= s_tdata[IN_RDY_BIT];
			has_q   <= s_tdata[IN_HAS_BIT];
			addr_q  <= s_tdata[IN_ADDR_LSB +: ADDR_W];
			itime_q <= s_tdata[IN_TIME_LSB +: TIME_W];
			lim_q   <= lim;
		end
	end

	// ------------------------------------------------------------------
	// Window pointers and count
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_insert) begin
				head_q  <= ptr_next(head_q);
				count_q <= count_q + 1'b1;
			end
			if (ret_step) begin
				tail_q  <= ptr_next(tail_q);
				count_q <= count_q - 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result accumulators
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			found_q <= 1'b0;
			best_q  <= '0;
			rej_q   <= 1'b0;
		end else if (in_acc) begin
			n_q     <= '0;
			found_q <= 1'b0;
			best_q  <= '0;
			rej_q   <= 1'b0;
		end else begin
			if (state_q == ST_INSERT && full) begin
				rej_q <= 1'b1;
			end
			if (ret_step) begin
				n_q <= n_q + 1'b1;
			end
			// stage s2: running minimum of matching issue times
			if (hit_s2) begin
				found_q <= 1'b1;
				if (!found_q || (time_s2 < best_q)) begin
					best_q <= time_s2;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Scan sequencer: one read a cycle from tail over count entries
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_left_q <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			hit_s2       <= 1'b0;
		end else begin
			if (in_acc && op_in == OP_COMPLETE) begin
				issue_left_q <= count_q;
			end else if (scan_issue) begin
				issue_left_q <= issue_left_q - 1'b1;
			end
			v_s1   <= scan_issue;
			v_s2   <= v_s1;
			hit_s2 <= hit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			scan_idx_q <= tail_q;
		end else if (scan_issue) begin
			scan_idx_q <= ptr_next(scan_idx_q);
		end
		idx_s1  <= scan_idx_q;
		time_s2 <= rd_time;
	end

	// ------------------------------------------------------------------
	// Output register: holds the result word until taken
	// ------------------------------------------------------------------
	always_comb begin
		resp_word = '0;
		resp_word[OUT_RCNT_LSB +: RCNT_W] = RCNT_W'(n_q);
		resp_word[OUT_FOUND_BIT]          = found_q;
		resp_word[OUT_TIME_LSB +: TIME_W] = best_q;
		resp_word[OUT_REJ_BIT]            = rej_q;
		resp_word[OUT_FULL_BIT]           = full;
		resp_word[OUT_OCC_LSB +: OCC_W]   = OCC_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (resp_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			m_tdata_q <= resp_word;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== rtl/iwr_entry_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module iwr_entry_ram #(
	parameter int DEPTH_P = 128,
	parameter int WIDTH_P = 96
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH_P)-1:0] waddr,
	input  logic [WIDTH_P-1:0]         wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH_P)-1:0] raddr,
	output logic [WIDTH_P-1:0]         rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/iwr_checker.sv =====
// Port-level checker for the instruction window, bound to the top level.
`timescale 1ns / 1ps
`include "instruction_window_rob_core_macros.svh"
module iwr_checker
	import iwr_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// a word on offer stays until taken
	`IWR_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result word dropped")

	// full flag agrees with reported occupancy
	`IWR_ASSERT_NOW(a_full_occ, clk, arst_n, m_tvalid, m_tdata[OUT_FULL_BIT] == (m_tdata[OUT_OCC_LSB +: OCC_W] == OCC_W'(DEPTH)), "full flag and occupancy disagree")

	// a refused insert only happens on a full window
	`IWR_ASSERT_NOW(a_rej_full, clk, arst_n, m_tvalid && m_tdata[OUT_REJ_BIT], m_tdata[OUT_FULL_BIT], "insert refused while not full")

	// no match means zero time
	`IWR_ASSERT_NOW(a_nomatch, clk, arst_n, m_tvalid && !m_tdata[OUT_FOUND_BIT], m_tdata[OUT_TIME_LSB +: TIME_W] == '0, "time reported without match")

	// retire never exceeds its cap
	`IWR_ASSERT_NOW(a_ret_cap, clk, arst_n, m_tvalid, int'(m_tdata[OUT_RCNT_LSB +: RCNT_W]) <= MAX_RETIRE, "retire count above cap")

endmodule

bind instruction_window_rob_core iwr_checker u_iwr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
